/* src/glmt_pkg.sv */
// shared constants, types and helpers of the longest-match tokenizer
package glmt_pkg;

    localparam int VOCAB_DEPTH = 32768;
    localparam int MAX_PIECE   = 16;
    localparam int AW          = $clog2(VOCAB_DEPTH);
    localparam int PW          = $clog2(MAX_PIECE);
    localparam int CW          = $clog2(MAX_PIECE + 1);
    localparam int ID_W        = 15;
    localparam int LEN_W       = 5;

    localparam logic [1:0] REG_VOCAB_COUNT = 2'd0;
    localparam logic [1:0] REG_MAX_PIECE   = 2'd1;
    localparam logic [1:0] REG_END_ID      = 2'd2;

    typedef logic [MAX_PIECE-1:0][7:0] t_str;

    typedef struct packed {
        t_str              str;
        logic [LEN_W-1:0]  len;
        logic [ID_W-1:0]   id;
    } t_row;

    typedef struct packed {
        logic hit;
        logic hex_hit;
        logic prefix;
    } t_match;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
    endfunction

endpackage

/* src/glmt_vocab.sv */
// vocabulary tables: entry rows and the id to slot map
module glmt_vocab (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [glmt_pkg::ID_W-1:0] i_wr_slot,
    input  logic [3:0]                i_wr_pos,
    input  logic [7:0]                i_wr_byte,
    input  logic [glmt_pkg::LEN_W-1:0] i_wr_len,
    input  logic [glmt_pkg::ID_W-1:0] i_wr_id,
    input  logic [glmt_pkg::AW-1:0]   i_row_addr,
    output glmt_pkg::t_row            o_row,
    input  logic [glmt_pkg::AW-1:0]   i_map_addr,
    output logic [glmt_pkg::AW-1:0]   o_map_slot
);
    import glmt_pkg::*;

    t_str             m_str [VOCAB_DEPTH];
    logic [LEN_W-1:0] m_len [VOCAB_DEPTH];
    logic [ID_W-1:0]  m_id  [VOCAB_DEPTH];
    logic [AW-1:0]    m_map [VOCAB_DEPTH];

    logic slot_ok, pos_ok, id_ok;
    assign slot_ok = 32'(i_wr_slot) < VOCAB_DEPTH;
    assign pos_ok  = 32'(i_wr_pos) < MAX_PIECE;
    assign id_ok   = 32'(i_wr_id) < VOCAB_DEPTH;

    always_ff @(posedge i_clk) begin
        if (i_we && slot_ok) begin
            if (pos_ok) begin
                m_str[AW'(i_wr_slot)][PW'(i_wr_pos)] <= i_wr_byte;
            end
            m_len[AW'(i_wr_slot)] <= i_wr_len;
            m_id[AW'(i_wr_slot)]  <= i_wr_id;
            if (id_ok) begin
                m_map[AW'(i_wr_id)] <= AW'(i_wr_slot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_row.str  <= m_str[i_row_addr];
        o_row.len  <= m_len[i_row_addr];
        o_row.id   <= m_id[i_row_addr];
        o_map_slot <= m_map[i_map_addr];
    end

endmodule

/* src/glmt_match.sv */
// compares one table row against the lookahead bytes
module glmt_match (
    input  glmt_pkg::t_row                 i_row,
    input  glmt_pkg::t_str                 i_la,
    input  logic [glmt_pkg::CW-1:0]        i_cnt,
    input  logic [glmt_pkg::CW-1:0]        i_maxp,
    output glmt_pkg::t_match               o_match
);
    import glmt_pkg::*;

    logic [MAX_PIECE-1:0] eq, allow;
    logic [5:0][7:0]      key;
    int                   lim;
    logic                 len_ok, pre, hex_eq;

    always_comb begin
        lim = (i_maxp < i_cnt) ? int'(i_maxp) : int'(i_cnt);
        for (int i = 0; i < MAX_PIECE; i++) begin
            eq[i]    = i_row.str[i] == i_la[i];
            // a length may end in a utf-8 sequence only at maxp or i_cnt
            allow[i] = (i + 1 <= lim) &&
                       !((i_la[i][7:6] == 2'b10) && (i + 1 < int'(i_maxp)) &&
                         (i + 1 < int'(i_cnt)));
        end
        len_ok = (i_row.len != '0) && (int'(i_row.len) <= MAX_PIECE);
        pre    = len_ok;
        for (int i = 0; i < MAX_PIECE; i++) begin
            if (i < int'(i_row.len) && !eq[i]) pre = 1'b0;
        end
        key[0] = 8'h3C;
        key[1] = 8'h30;
        key[2] = 8'h78;
        key[3] = hex_char(i_la[0][7:4]);
        key[4] = hex_char(i_la[0][3:0]);
        key[5] = 8'h3E;
        hex_eq = (MAX_PIECE >= 6) && (int'(i_row.len) == 6);
        for (int i = 0; i < 6; i++) begin
            if (i < MAX_PIECE && i_row.str[i % MAX_PIECE] != key[i]) hex_eq = 1'b0;
        end
        o_match.prefix  = pre;
        o_match.hit     = pre && allow[PW'(i_row.len - 5'd1)];
        o_match.hex_hit = hex_eq;
    end

endmodule

/* src/greedy_longest_match_tokenizer_unit.sv */
// top level of the greedy longest-match tokenizer with byte fallback
// Words on the input stream either load one byte of a vocabulary entry (tuser = 0) or carry
// one text byte (tuser = 1). Text bytes wait in a 16-byte lookahead; once max_piece_bytes
// are held (or on tlast) the block emits tokens one at a time. Every lookahead token costs one
// full linear pass over the vocabulary table: one row read per cycle through a single shared row
// compare unit, plus the wait for the output stream. While the start-token check is pending,
// each text byte also passes through the mapped-slot row read S_SKB and the row compare S_SKC.
// The input is not ready while a text byte is being worked on. Results leave through a
// one-deep hold stage so that tlast can mark the final token caused by a word.
module greedy_longest_match_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // slot, entry_id, entry_len, byte_pos, data_byte, first_of_text, start_token, append_end
    input  logic [63:0] i_s_axis_tdata,
    // req_type
    input  logic        i_s_axis_tuser,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // token, one zero fill bit
    output logic [15:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import glmt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SKA   = 4'd1;
    localparam logic [3:0] S_SKB   = 4'd2;
    localparam logic [3:0] S_SKC   = 4'd3;
    localparam logic [3:0] S_TOK   = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_DEC   = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_END   = 4'd8;
    localparam logic [3:0] S_FLUSH = 4'd9;

    // input word fields
    logic [ID_W-1:0]  f_slot, f_eid, f_start;
    logic [LEN_W-1:0] f_len;
    logic [3:0]       f_pos;
    logic [7:0]       f_byte;
    logic             f_first, f_add_end;
    assign f_slot    = i_s_axis_tdata[14:0];
    assign f_eid     = i_s_axis_tdata[29:15];
    assign f_len     = i_s_axis_tdata[34:30];
    assign f_pos     = i_s_axis_tdata[38:35];
    assign f_byte    = i_s_axis_tdata[46:39];
    assign f_first   = i_s_axis_tdata[47];
    assign f_start   = i_s_axis_tdata[62:48];
    assign f_add_end = i_s_axis_tdata[63];

    // configuration registers
    logic [15:0]     r_vocab;
    logic [4:0]      r_maxp_cfg;
    logic [ID_W-1:0] r_end_id;
    logic            cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vocab    <= '0;
            r_maxp_cfg <= 5'd16;
            r_end_id   <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_VOCAB_COUNT: r_vocab    <= pwdata[15:0];
                REG_MAX_PIECE:   r_maxp_cfg <= pwdata[4:0];
                REG_END_ID:      r_end_id   <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_VOCAB_COUNT: prdata = {16'h0, r_vocab};
            REG_MAX_PIECE:   prdata = {27'h0, r_maxp_cfg};
            REG_END_ID:      prdata = {17'h0, r_end_id};
            default:         prdata = '0;
        endcase
    end

    // effective piece limit and table size
    logic [CW-1:0] maxp;
    logic [AW:0]   n_rows;
    always_comb begin
        if (r_maxp_cfg == '0)                  maxp = CW'(1);
        else if (int'(r_maxp_cfg) > MAX_PIECE) maxp = CW'(MAX_PIECE);
        else                                   maxp = CW'(r_maxp_cfg);
        n_rows = (int'(r_vocab) > VOCAB_DEPTH) ? (AW+1)'(VOCAB_DEPTH) : (AW+1)'(r_vocab);
    end

    // control and datapath state
    logic [3:0]      r_state, n_state, r_ret, n_ret;
    t_str            r_la, n_la;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_pend, n_pend;
    logic [ID_W-1:0] r_target, n_target;
    logic            r_final, n_final, r_add_end, n_add_end;
    logic [ID_W-1:0] r_tok, n_tok;
    logic            r_hold_v, n_hold_v;
    logic [ID_W-1:0] r_hold_tok, n_hold_tok;
    logic            r_out_v, n_out_v, r_out_last, n_out_last;
    logic [ID_W-1:0] r_out_tok, n_out_tok;
    logic [AW:0]     r_addr, n_addr;
    logic            r_rd_v, n_rd_v;
    logic [CW-1:0]   r_top_len, n_top_len;
    logic [ID_W-1:0] r_best_id, n_best_id;
    logic            r_hex_v, n_hex_v;
    logic [ID_W-1:0] r_hex_id, n_hex_id;

    logic            in_acc, load_we, out_free;
    t_row            row;
    t_match          mtch;
    logic [AW-1:0]   map_slot, row_addr;
    logic [CW-1:0]   drop_k;
    logic            drop_en;
    t_str            la_app, la_drop;
    logic [CW-1:0]   cnt_base;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign load_we  = in_acc && !i_s_axis_tuser;
    assign out_free = !r_out_v || i_m_axis_tready;
    assign row_addr = (r_state == S_SKB) ? map_slot : r_addr[AW-1:0];

    glmt_vocab u_vocab (
        .i_clk      (i_clk),
        .i_we       (load_we),
        .i_wr_slot  (f_slot),
        .i_wr_pos   (f_pos),
        .i_wr_byte  (f_byte),
        .i_wr_len   (f_len),
        .i_wr_id    (f_eid),
        .i_row_addr (row_addr),
        .o_row      (row),
        .i_map_addr (r_target[AW-1:0]),
        .o_map_slot (map_slot)
    );

    glmt_match u_match (
        .i_row   (row),
        .i_la    (r_la),
        .i_cnt   (r_cnt),
        .i_maxp  (maxp),
        .o_match (mtch)
    );

    // lookahead append and front drop
    always_comb begin
        cnt_base = f_first ? '0 : r_cnt;
        la_app   = r_la;
        if (int'(cnt_base) < MAX_PIECE) la_app[PW'(cnt_base)] = f_byte;
        for (int i = 0; i < MAX_PIECE; i++) begin
            la_drop[i] = (i + int'(drop_k) < MAX_PIECE) ?
                         r_la[PW'((i + int'(drop_k)) % MAX_PIECE)] : 8'h00;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_la       = r_la;
        n_cnt      = r_cnt;
        n_pend     = r_pend;
        n_target   = r_target;
        n_final    = r_final;
        n_add_end  = r_add_end;
        n_tok      = r_tok;
        n_hold_v   = r_hold_v;
        n_hold_tok = r_hold_tok;
        n_out_v    = r_out_v && !i_m_axis_tready;
        n_out_tok  = r_out_tok;
        n_out_last = r_out_last;
        n_addr     = r_addr;
        n_rd_v     = r_rd_v;
        n_top_len  = r_top_len;
        n_best_id  = r_best_id;
        n_hex_v    = r_hex_v;
        n_hex_id   = r_hex_id;
        drop_k     = '0;
        drop_en    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_s_axis_tuser) begin
                    n_la      = la_app;
                    n_cnt     = (int'(cnt_base) < MAX_PIECE) ? cnt_base + CW'(1) : cnt_base;
                    n_final   = i_s_axis_tlast;
                    n_add_end = f_add_end;
                    n_state   = S_SKA;
                    if (f_first) begin
                        n_pend = 1'b0;
                        if (f_start != '0) begin
                            n_pend   = 1'b1;
                            n_target = f_start;
                            n_tok    = f_start;
                            n_ret    = S_SKA;
                            n_state  = S_EMIT;
                        end
                    end
                end
            end
            S_SKA: begin
                // the map read of the start token's slot is issued here
                if (!r_pend) begin
                    n_state = S_TOK;
                end else if (32'(r_target) >= VOCAB_DEPTH) begin
                    n_pend  = 1'b0;
                    n_state = S_TOK;
                end else begin
                    n_state = S_SKB;
                end
            end
            S_SKB: n_state = S_SKC;
            S_SKC: begin
                n_state = S_TOK;
                if (row.len == '0 || int'(row.len) > MAX_PIECE) begin
                    n_pend = 1'b0;
                end else if (int'(r_cnt) >= int'(row.len)) begin
                    if (mtch.prefix) begin
                        drop_k  = CW'(row.len);
                        drop_en = 1'b1;
                    end
                    n_pend = 1'b0;
                end else if (r_final) begin
                    n_pend = 1'b0;
                end
            end
            S_TOK: begin
                if (!r_pend && (r_final ? (r_cnt != '0) : (r_cnt >= maxp))) begin
                    n_addr     = '0;
                    n_rd_v     = 1'b0;
                    n_top_len  = '0;
                    n_hex_v    = 1'b0;
                    n_state    = S_SCAN;
                end else begin
                    n_state = S_END;
                end
            end
            S_SCAN: begin
                // one row read per cycle, the compare of each row runs in the cycle after its read
                if (r_rd_v) begin
                    if (mtch.hit && int'(row.len) > int'(r_top_len)) begin
                        n_top_len = CW'(row.len);
                        n_best_id = row.id;
                    end
                    if (mtch.hex_hit && !r_hex_v) begin
                        n_hex_v  = 1'b1;
                        n_hex_id = row.id;
                    end
                end
                if (r_addr < n_rows) begin
                    n_addr = r_addr + (AW+1)'(1);
                    n_rd_v = 1'b1;
                end else begin
                    n_rd_v = 1'b0;
                    if (!r_rd_v) n_state = S_DEC;
                end
            end
            S_DEC: begin
                drop_en = 1'b1;
                if (r_top_len != '0) begin
                    drop_k = r_top_len;
                    n_tok  = r_best_id;
                end else begin
                    drop_k = CW'(1);
                    n_tok  = r_hex_v ? r_hex_id : ({7'h0, r_la[0]} + ID_W'(3));
                end
                n_ret   = S_TOK;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_hold_v) begin
                    n_hold_v   = 1'b1;
                    n_hold_tok = r_tok;
                    n_state    = r_ret;
                end else if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_tok  = r_hold_tok;
                    n_out_last = 1'b0;
                    n_hold_tok = r_tok;
                    n_state    = r_ret;
                end
            end
            S_END: begin
                if (r_final && r_add_end) begin
                    n_tok   = r_end_id;
                    n_ret   = S_FLUSH;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // the held token is the last one this word causes
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_tok  = r_hold_tok;
                    n_out_last = 1'b1;
                    n_hold_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (drop_en) begin
            n_la  = la_drop;
            n_cnt = (drop_k > r_cnt) ? '0 : r_cnt - drop_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_la     <= '0;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_target <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_rd_v   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_la     <= n_la;
            r_cnt    <= n_cnt;
            r_pend   <= n_pend;
            r_target <= n_target;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
            r_rd_v   <= n_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_final    <= n_final;
        r_add_end  <= n_add_end;
        r_tok      <= n_tok;
        r_hold_tok <= n_hold_tok;
        r_out_tok  <= n_out_tok;
        r_out_last <= n_out_last;
        r_addr     <= n_addr;
        r_top_len  <= n_top_len;
        r_best_id  <= n_best_id;
        r_hex_v    <= n_hex_v;
        r_hex_id   <= n_hex_id;
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {1'b0, r_out_tok};
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_hold_v)
        else $error("token held while idle");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= MAX_PIECE)
        else $error("lookahead count overflow");
    a_last_ends_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && r_hold_v && out_free) |=> r_state == S_IDLE)
        else $error("flush did not end the word");
`endif

endmodule

/* tb/greedy_longest_match_tokenizer_unit_tb.sv */
// self-checking testbench of the greedy longest-match tokenizer unit
`timescale 1ns / 100ps

module greedy_longest_match_tokenizer_unit_tb;
    import glmt_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int NV          = 24;       // slots 0..NV-1 are loaded and may be scanned
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_WORDS  = 100;      // text words of the random phases

    // one input word, unpacked
    typedef struct {
        bit        req;
        bit [14:0] slot;
        bit [14:0] eid;
        bit [4:0]  elen;
        bit [3:0]  pos;
        bit [7:0]  b;
        bit        first;
        bit        fin;
        bit [14:0] start;
        bit        add_end;
    } t_word;

    typedef struct {
        bit [14:0] tok;
        bit        last;
    } t_tok;

    // token predictor plus the queue of tokens still owed by the block
    class t_token_scoreboard;
        bit [15:0][7:0] ent_str[int];
        bit [4:0]       ent_len[int];
        bit [14:0]      ent_id[int];
        bit [14:0]      id_slot[int];
        bit [7:0]       la[$];
        bit             skip_pend;
        bit [14:0]      skip_id;
        int             vc;
        int             mp;
        bit [14:0]      end_tok;
        t_tok           cur[$];
        t_tok           exp_q[$];
        int             errors;
        int             n_tok;
        int             n_text;

        function new();
            vc = 0;
            mp = 16;
            end_tok = 0;
        endfunction

        function void set_reg(logic [1:0] idx, bit [31:0] val);
            case (idx)
                REG_VOCAB_COUNT: vc = val[15:0];
                REG_MAX_PIECE:   mp = val[4:0];
                REG_END_ID:      end_tok = val[14:0];
                default: ;
            endcase
        endfunction

        function int piece_lim();
            if (mp == 0) return 1;
            return (mp > MAX_PIECE) ? MAX_PIECE : mp;
        endfunction

        // first scanned slot whose stored string equals key[0..n-1]
        function bit lookup(bit [7:0] key[$], int n, output bit [14:0] id);
            int top;
            bit same;
            top = (vc > VOCAB_DEPTH) ? VOCAB_DEPTH : vc;
            id = 0;
            if (n == 0 || n > MAX_PIECE) return 0;
            for (int s = 0; s < top; s++) begin
                if (ent_len.exists(s) && ent_len[s] == n) begin
                    same = 1;
                    for (int k = 0; k < n; k++)
                        if (ent_str[s][k] != key[k]) same = 0;
                    if (same) begin
                        id = ent_id[s];
                        return 1;
                    end
                end
            end
            return 0;
        endfunction

        function bit [7:0] hexc(bit [3:0] n);
            return (n < 10) ? 8'h30 + n : 8'h37 + n;
        endfunction

        function void emit(bit [14:0] id);
            cur.push_back('{id, 1'b0});
        endfunction

        function void one_token();
            int maxp, lim, top_len;
            bit [14:0] id, best_id;
            bit [7:0] key[$];
            bit [7:0] b;
            maxp = piece_lim();
            lim = (maxp < la.size()) ? maxp : la.size();
            top_len = 0;
            best_id = 0;
            for (int n = 1; n <= lim; n++) begin
                // a piece may not end inside a utf-8 sequence unless forced
                if (la[n-1][7:6] == 2'b10 && n < maxp && n < la.size()) continue;
                if (lookup(la, n, id)) begin
                    top_len = n;
                    best_id = id;
                end
            end
            if (top_len != 0) begin
                repeat (top_len) void'(la.pop_front());
                emit(best_id);
                return;
            end
            // byte fallback: "<0xHH>" entry, else byte + 3
            b = la.pop_front();
            key = '{8'h3C, 8'h30, 8'h78, hexc(b[7:4]), hexc(b[3:0]), 8'h3E};
            if (lookup(key, 6, id)) emit(id);
            else emit(15'(b) + 15'd3);
        endfunction

        function void resolve_skip(bit fin);
            int s, n;
            bit same;
            if (!skip_pend) return;
            s = id_slot[skip_id];
            n = ent_len[s];
            if (n == 0 || n > MAX_PIECE) begin
                skip_pend = 0;
            end else if (la.size() >= n) begin
                same = 1;
                for (int k = 0; k < n; k++)
                    if (la[k] != ent_str[s][k]) same = 0;
                if (same) repeat (n) void'(la.pop_front());
                skip_pend = 0;
            end else if (fin) begin
                skip_pend = 0;
            end
        endfunction

        // an input word was accepted
        function void note_word(t_word w);
            if (!w.req) begin
                if (!ent_str.exists(w.slot)) ent_str[w.slot] = '0;
                ent_str[w.slot][w.pos] = w.b;
                ent_len[w.slot] = w.elen;
                ent_id[w.slot] = w.eid;
                id_slot[w.eid] = w.slot;
                return;
            end
            n_text++;
            cur.delete();
            if (w.first) begin
                la.delete();
                skip_pend = 0;
                if (w.start > 0) begin
                    emit(w.start);
                    skip_pend = 1;
                    skip_id = w.start;
                end
            end
            if (la.size() < MAX_PIECE) la.push_back(w.b);
            resolve_skip(w.fin);
            if (!skip_pend) begin
                if (w.fin) while (la.size() > 0) one_token();
                else while (la.size() >= piece_lim()) one_token();
            end
            if (w.fin && w.add_end) emit(end_tok);
            if (cur.size() > 0) cur[cur.size()-1].last = 1;
            foreach (cur[i]) exp_q.push_back(cur[i]);
        endfunction

        // an output word was accepted
        function void check_token(bit [14:0] tok, bit last);
            t_tok e;
            n_tok++;
            if (exp_q.size() == 0) begin
                $error("unexpected token %0d", tok);
                errors++;
                return;
            end
            e = exp_q.pop_front();
            if (tok !== e.tok) begin
                $error("token: expected %0d, actual %0d", e.tok, tok);
                errors++;
            end
            if (last !== e.last) begin
                $error("token_last: expected %0d, actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // slot, entry_id, entry_len, byte_pos, data_byte, first_of_text, start_token, append_end
    logic [63:0] i_s_axis_tdata;
    // req_type
    logic        i_s_axis_tuser;
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // token, one zero fill bit
    logic [15:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    greedy_longest_match_tokenizer_unit uut (.*);

    t_token_scoreboard sb = new();
    int  cycles;
    bit  hold_req;    // ask the receiver for one long hold-off
    bit  no_idle;     // phases with no gaps on either side
    int  ids[$];      // token ids that are loaded, usable as start tokens

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // timeout guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("greedy_longest_match_tokenizer_unit regression: fail");
            $finish;
        end
    end

    // result checking at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_token(o_m_axis_tdata[14:0], o_m_axis_tlast);
    end

    // receiver: random stalls, an occasional long one, and the requested hold-off
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 0;
            end else if (no_idle) begin
                i_m_axis_tready = 1'b1;
            end else if ($urandom_range(0, 99) < 3) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(15, 60)) @(negedge i_clk);
            end else begin
                i_m_axis_tready = ($urandom_range(0, 99) < 70);
            end
        end
    end

    function int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function bit [15:0][7:0] str16(string t);
        bit [15:0][7:0] r;
        r = '0;
        for (int k = 0; k < t.len(); k++) r[k] = t[k];
        return r;
    endfunction

    function t_word rnd_word();
        t_word w;
        w.req = $urandom;
        w.slot = $urandom;
        w.eid = $urandom;
        w.elen = $urandom;
        w.pos = $urandom;
        w.b = $urandom;
        w.first = $urandom;
        w.fin = $urandom;
        w.start = $urandom;
        w.add_end = $urandom;
        return w;
    endfunction

    task send_word(t_word w);
        int g;
        g = gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (g) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_s_axis_tdata = {w.add_end, w.start, w.first, w.b, w.pos, w.elen, w.eid, w.slot};
        i_s_axis_tuser = w.req;
        i_s_axis_tlast = w.fin;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_word(w);
    endtask

    task apb_write(logic [1:0] idx, bit [31:0] val);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // stop offering, every owed token is out, then let any tokenless work finish
    task wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task set_regs(int vc, int mp, int eid);
        wait_idle();
        apb_write(REG_VOCAB_COUNT, vc);
        apb_write(REG_MAX_PIECE, mp);
        apb_write(REG_END_ID, eid);
    endtask

    // one vocabulary entry, one word per stored byte
    task load_entry(int slot, bit [14:0] eid, bit [15:0][7:0] s, bit [4:0] n);
        t_word w;
        int nb;
        nb = (n == 0 || n > MAX_PIECE) ? 1 : n;
        for (int k = 0; k < nb; k++) begin
            w = rnd_word();
            w.req = 1'b0;
            w.slot = slot;
            w.eid = eid;
            w.elen = n;
            w.pos = k;
            w.b = s[k];
            send_word(w);
        end
        ids.push_back(eid);
    endtask

    function bit [7:0] vocab_byte();
        bit [7:0] alpha[7] = '{8'h61, 8'h62, 8'h63, 8'hC3, 8'hA9, 8'h80, 8'h00};
        return alpha[$urandom_range(0, 6)];
    endfunction

    function bit [15:0][7:0] rnd_str(int n);
        bit [15:0][7:0] r;
        r = '0;
        for (int k = 0; k < n; k++) r[k] = vocab_byte();
        return r;
    endfunction

    function bit [14:0] pick_start();
        if ($urandom_range(0, 1)) return 0;
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    // a text of about n bytes; optionally led by the start token's own string
    task send_text(int n, bit [14:0] start, bit add_end, bit lead_skip,
                   bit with_first = 1, bit with_last = 1);
        bit [7:0] txt[$];
        t_word w;
        int s, m;
        if (lead_skip && start != 0) begin
            s = sb.id_slot[start];
            m = sb.ent_len[s];
            if (m <= MAX_PIECE)
                for (int k = 0; k < m; k++) txt.push_back(sb.ent_str[s][k]);
        end
        while (txt.size() < n) begin
            if ($urandom_range(0, 99) < 75) begin
                s = $urandom_range(0, NV - 1);
                m = sb.ent_len[s];
                if (m <= MAX_PIECE)
                    for (int k = 0; k < m; k++) txt.push_back(sb.ent_str[s][k]);
            end else if ($urandom_range(0, 1)) begin
                txt.push_back($urandom);
            end else begin
                txt.push_back(vocab_byte());
            end
        end
        while (txt.size() > n && txt.size() > 1) void'(txt.pop_back());
        foreach (txt[i]) begin
            w = rnd_word();
            w.req = 1'b1;
            w.b = txt[i];
            w.first = with_first && (i == 0);
            w.fin = with_last && (i == txt.size() - 1);
            w.start = start;
            w.add_end = add_end;
            send_word(w);
        end
    endtask

    task send_bytes(bit [7:0] bs[$], bit add_end);
        t_word w;
        foreach (bs[i]) begin
            w = rnd_word();
            w.req = 1'b1;
            w.b = bs[i];
            w.first = (i == 0);
            w.fin = (i == bs.size() - 1);
            w.start = 0;
            w.add_end = add_end;
            send_word(w);
        end
    endtask

    int settings[8][3] = '{
        '{NV, 16, 32767}, '{NV, 1, 0},  '{NV, 4, 12345}, '{0, 16, 1},
        '{NV, 0, 32767},  '{NV, 31, 7}, '{12, 16, 22222}, '{NV, 6, 5}
    };

    initial begin
        int target;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        i_s_axis_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 0;
        no_idle = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // vocabulary: prefixes, utf-8 pieces, empty and overlong entries,
        // a duplicate string and two hex fallback entries
        load_entry(0, $urandom, str16("a"), 1);
        load_entry(1, $urandom, str16("ab"), 2);
        load_entry(2, $urandom, str16("abc"), 3);
        load_entry(3, $urandom, {112'h0, 16'hA9C3}, 2);
        load_entry(4, $urandom, {120'h0, 8'hC3}, 1);
        load_entry(5, $urandom, rnd_str(16), 16);
        load_entry(6, $urandom, str16("c"), 0);
        load_entry(7, $urandom, rnd_str(16), 20);
        load_entry(8, $urandom, str16("b"), 1);
        load_entry(9, $urandom, str16("b"), 1);
        load_entry(10, $urandom, str16("<0x7A>"), 6);
        load_entry(11, $urandom, str16("<0x00>"), 6);
        for (int s = 12; s < NV; s++) begin
            int n;
            n = $urandom_range(1, 6);
            load_entry(s, $urandom, rnd_str(n), n);
        end
        // top slot and top id, outside the scanned range but a start token
        load_entry(VOCAB_DEPTH - 1, 15'h7FFF, str16("ca"), 2);

        // empty vocabulary at reset: only plain byte fallback
        send_bytes('{8'h61, 8'hFF}, 1'b1);

        set_regs(NV, 16, 32767);
        // directed texts
        send_bytes('{8'h61}, 1'b1);
        send_text(5, sb.ent_id[0], 1'b1, 1'b1);            // start text dropped
        send_bytes('{8'h7A, 8'hFF, 8'h00, 8'h62}, 1'b0);  // hex entries and byte + 3
        send_bytes('{8'h61, 8'hC3, 8'hA9, 8'h80, 8'hC3}, 1'b1);  // utf-8 boundaries
        send_text(3, sb.ent_id[6], 1'b0, 1'b0);            // zero-length start text
        send_text(2, sb.ent_id[5], 1'b1, 1'b0);            // text ends before skip length
        send_text(4, 15'h7FFF, 1'b1, 1'b1);                // top id as start token
        send_text(4, 15'h7FFF, 1'b0, 1'b0, 1, 0);          // left open, with no last byte
        send_text(3, 0, 1'b1, 1'b0, 1, 1);                 // new text discards it
        send_text(3, 0, 1'b0, 1'b0, 0, 1);                 // bytes after the end

        // random texts over several register settings
        target = sb.n_text + RAND_WORDS;
        for (int p = 0; p < 8; p++) begin
            set_regs(settings[p][0], settings[p][1], settings[p][2]);
            no_idle = (p == 2);
            if (p == 0) begin
                // receiver holds off while a long text keeps coming
                hold_req = 1;
                send_text(16, 0, 1'b1, 1'b0);
                send_text(16, 0, 1'b1, 1'b0);
            end
            if (p == 4) begin
                for (int s = 12; s < 20; s++) begin
                    int n;
                    n = $urandom_range(1, 6);
                    load_entry(s, $urandom, rnd_str(n), n);
                end
            end
            while (sb.n_text < target - (7 - p) * RAND_WORDS / 8) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 80) send_text($urandom_range(1, 12), pick_start(), $urandom,
                                      $urandom_range(0, 1));
                else if (r < 90) send_text($urandom_range(1, 5), pick_start(), $urandom,
                                           1'b0, 1, 0);
                else send_text($urandom_range(1, 5), 0, $urandom, 1'b0, 0, 1);
                if (p == 3 && $urandom_range(0, 9) == 0) begin
                    // sender waits for every owed token
                    @(negedge i_clk);
                    i_s_axis_tvalid = 1'b0;
                    while (sb.exp_q.size() != 0) @(posedge i_clk);
                end
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        wait_idle();

        $display("covered %0d text words and %0d tokens over %0d register settings",
                 sb.n_text, sb.n_tok, 9);
        $display("with vocabulary loads, start-text skips, byte fallback and stalls");
        if (sb.errors == 0 && sb.exp_q.size() == 0)
            $display("greedy_longest_match_tokenizer_unit regression: pass");
        else
            $display("greedy_longest_match_tokenizer_unit regression: fail");
        $finish;
    end

endmodule
